// ===== sv/bfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants
// controller states, register indexes and datapath command/status structs
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int unsigned FILTER_DEPTH_DEF = 65536;
    localparam int unsigned MAX_HASHES_DEF   = 4;
    localparam int unsigned COEF_WIDTH_DEF   = 16;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned PRIME_W = 32;
    localparam int unsigned BITS_W  = 17;
    localparam int unsigned HCNT_W  = 3;

    typedef enum logic [2:0] {
        REG_BIT_COUNT  = 3'd0,
        REG_HASH_COUNT = 3'd1,
        REG_PRIME      = 3'd2,
        REG_MULT       = 3'd3,
        REG_ADD        = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HASH_WAIT,
        ST_MODP,
        ST_MODP_WAIT,
        ST_MODM,
        ST_MODM_WAIT,
        ST_MEM,
        ST_MEM_WAIT,
        ST_DONE
    } bfm_state_t;

    typedef struct packed {
        logic clr_step;   // write zero at clear address, advance
        logic load;       // capture key and opcode
        logic hash_go;    // start multiply-add for current hash
        logic modp_go;    // start reduction by p
        logic modm_go;    // start reduction by m
        logic mem_rd;     // read filter bit at index
        logic mem_wr;     // set filter bit at index
        logic next_hash;  // advance hash counter, update all flag
        logic result;     // drive result strobe
    } bfm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic mod_done;
        logic last_hash;
        logic is_insert;
    } bfm_sts_t;

endpackage
`default_nettype wire

// ===== sv/bloom_filter_membership.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_membership: bloom filter with universal hashing
// insert or query a pre-hashed 64-bit key against a bit store
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. after reset the block
// runs a clearing pass over FILTER_DEPTH bits (65536 by default) with busy
// high. each hash runs a multiply-add (start, two 32-bit partial products,
// handoff), a serial mod p and a serial mod m (load, 64 shift steps and done
// in one shared restoring unit), and a bit store access. busy stays high from
// the accepting edge until all r hashes, r the effective hash count, and the
// result step are through. a query gives maybe_present with a one-cycle done
// strobe in the same cycle that busy falls; the receiver cannot stall, so it
// must take the result in that cycle. inserts give no result.
// ----------------------------------------------------------------------------
module bloom_filter_membership
    import bfm_pkg::*;
#(
    parameter int unsigned FILTER_DEPTH = FILTER_DEPTH_DEF,
    parameter int unsigned MAX_HASHES   = MAX_HASHES_DEF,
    parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              opcode,
    input  wire logic [KEY_W-1:0]  key,
    output logic                   done,
    output logic                   maybe_present,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [5:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    logic [BITS_W-1:0]  bit_count_reg;
    logic [HCNT_W-1:0]  hash_count_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic [KEY_W-1:0]   mult_reg;
    logic [KEY_W-1:0]   add_reg;
    logic               wr_en;
    reg_idx_t           ridx;
    bfm_cmd_t           cmd;
    bfm_sts_t           sts;
    logic               done_int;

    // registers sit 8 bytes apart
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= BITS_W'(65536);
            hash_count_reg <= HCNT_W'(4);
            prime_reg      <= PRIME_W'(65521);
            mult_reg       <= '0;
            add_reg        <= '0;
        end
        else if (wr_en && paddr[2:0] == 3'd0)
        begin
            case (ridx)
                REG_BIT_COUNT:  bit_count_reg  <= pwdata[BITS_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= pwdata[HCNT_W-1:0];
                REG_PRIME:      prime_reg      <= pwdata[PRIME_W-1:0];
                REG_MULT:       mult_reg       <= pwdata;
                REG_ADD:        add_reg        <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_BIT_COUNT:  prdata = 64'(bit_count_reg);
            REG_HASH_COUNT: prdata = 64'(hash_count_reg);
            REG_PRIME:      prdata = 64'(prime_reg);
            REG_MULT:       prdata = mult_reg;
            REG_ADD:        prdata = add_reg;
            default:        prdata = '0;
        endcase
    end

    bfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done_int)
    );

    bfm_datapath #(
        .FILTER_DEPTH (FILTER_DEPTH),
        .MAX_HASHES   (MAX_HASHES),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .key           (key),
        .bit_count     (bit_count_reg),
        .hash_count    (hash_count_reg),
        .prime_modulus (prime_reg),
        .mult_coeffs   (mult_reg),
        .add_coeffs    (add_reg),
        .maybe_present (maybe_present)
    );

    // result strobe is the controller's result command, registered
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_int;
        end
    end
    assign done = done_reg;

    // no result strobe directly follows an accept
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(start && !busy))
        else $error("result strobe right after accept");

    // a strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // accept only leaves idle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make block busy");

endmodule
`default_nettype wire

// ===== sv/bfm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_ram: generic single port ram
// one access per cycle (a write also reads the old word), registered read data
// ----------------------------------------------------------------------------
module bfm_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== sv/bfm_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_mod: serial restoring modulo unit
// 64-bit dividend reduced by a 32-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module bfm_mod
    import bfm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [KEY_W-1:0]   dividend,
    input  wire logic [PRIME_W-1:0] divisor,
    output logic                    done,
    output logic [PRIME_W-1:0]      remainder
);

    logic [KEY_W-1:0]   quo_reg, quo_next;
    logic [PRIME_W:0]   rem_reg, rem_next;
    logic [PRIME_W-1:0] div_reg, div_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PRIME_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[PRIME_W-1:0], quo_reg[KEY_W-1]};
        if (go)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 7'(KEY_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[PRIME_W-1:0];

endmodule
`default_nettype wire

// ===== sv/bfm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_datapath: hash arithmetic and filter store
// multiply-add over partial products, serial mod p and mod m, bit ram
// ----------------------------------------------------------------------------
module bfm_datapath
    import bfm_pkg::*;
#(
    parameter int unsigned FILTER_DEPTH = FILTER_DEPTH_DEF,
    parameter int unsigned MAX_HASHES   = MAX_HASHES_DEF,
    parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bfm_cmd_t           cmd,
    output bfm_sts_t                sts,
    input  wire logic               opcode,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic [BITS_W-1:0]  bit_count,
    input  wire logic [HCNT_W-1:0]  hash_count,
    input  wire logic [PRIME_W-1:0] prime_modulus,
    input  wire logic [KEY_W-1:0]   mult_coeffs,
    input  wire logic [KEY_W-1:0]   add_coeffs,
    output logic                    maybe_present
);

    localparam int unsigned AW  = $clog2(FILTER_DEPTH);
    localparam int unsigned HW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int unsigned MW  = $clog2(FILTER_DEPTH + 1);
    localparam int unsigned PW  = 32 + COEF_WIDTH;

    logic [KEY_W-1:0]   key_reg;
    logic               op_reg;
    logic [HW-1:0]      hidx_reg;
    logic               all_reg;
    logic [AW-1:0]      clr_reg;
    logic [KEY_W-1:0]   hval_reg;
    logic [1:0]         pp_reg;
    logic               pp_busy_reg;
    logic               hash_done_reg;
    logic               sel_m_reg;
    logic [PRIME_W-1:0] mod_in_reg;
    logic [AW-1:0]      pos_reg;
    logic               res_reg;

    logic [COEF_WIDTH-1:0] a_i, b_i;
    logic [KEY_W-1:0]      pp;
    logic [MW-1:0]         m_eff;
    logic [HCNT_W-1:0]     r_eff;
    logic                  mod_go, mod_done;
    logic [KEY_W-1:0]      mod_dvd;
    logic [PRIME_W-1:0]    mod_dvs, mod_rem;
    logic                  ram_we, ram_wd, ram_rd;
    logic [AW-1:0]         ram_addr;

    // coefficient fields starting above bit 63 read as zero
    always_comb
    begin
        a_i = '0;
        b_i = '0;
        for (int k = 0; k < MAX_HASHES; k++)
        begin
            if (k * COEF_WIDTH < KEY_W && HW'(k) == hidx_reg)
            begin
                a_i = COEF_WIDTH'(mult_coeffs >> (k * COEF_WIDTH));
                b_i = COEF_WIDTH'(add_coeffs >> (k * COEF_WIDTH));
            end
        end
    end

    // effective m and r with the saturation rules
    always_comb
    begin
        if (bit_count == '0)
        begin
            m_eff = MW'(1);
        end
        else if (32'(bit_count) > FILTER_DEPTH)
        begin
            m_eff = MW'(FILTER_DEPTH);
        end
        else
        begin
            m_eff = MW'(bit_count);
        end
        if (hash_count == '0)
        begin
            r_eff = HCNT_W'(1);
        end
        else if (32'(hash_count) > MAX_HASHES)
        begin
            r_eff = HCNT_W'(MAX_HASHES);
        end
        else
        begin
            r_eff = hash_count;
        end
    end

    // one 32-bit slice of the key times the coefficient per cycle
    assign pp = (pp_reg == 2'd0)
        ? KEY_W'(PW'(key_reg[31:0]) * PW'(a_i))
        : {key_reg[63:32] * 32'(a_i), 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_busy_reg   <= 1'b0;
            hash_done_reg <= 1'b0;
            pp_reg        <= '0;
            hidx_reg      <= '0;
            all_reg       <= 1'b1;
            clr_reg       <= '0;
            sel_m_reg     <= 1'b0;
            res_reg       <= 1'b0;
        end
        else
        begin
            hash_done_reg <= 1'b0;
            res_reg       <= 1'b0;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                hidx_reg <= '0;
                all_reg  <= 1'b1;
            end
            if (cmd.hash_go)
            begin
                pp_busy_reg <= 1'b1;
                pp_reg      <= '0;
            end
            else if (pp_busy_reg)
            begin
                pp_reg <= pp_reg + 2'd1;
                if (pp_reg == 2'd1)
                begin
                    pp_busy_reg   <= 1'b0;
                    hash_done_reg <= 1'b1;
                end
            end
            if (cmd.modp_go)
            begin
                sel_m_reg <= 1'b0;
            end
            if (cmd.modm_go)
            begin
                sel_m_reg <= 1'b1;
            end
            if (cmd.next_hash)
            begin
                hidx_reg <= hidx_reg + HW'(1);
                if (op_reg && !ram_rd)
                begin
                    all_reg <= 1'b0;
                end
            end
            if (cmd.result)
            begin
                res_reg <= all_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
            op_reg  <= opcode;  // high for query
        end
        if (cmd.hash_go)
        begin
            hval_reg <= KEY_W'(b_i);
        end
        else if (pp_busy_reg)
        begin
            hval_reg <= hval_reg + pp;
        end
        if (mod_done && !sel_m_reg)
        begin
            mod_in_reg <= mod_rem;
        end
        if (mod_done && sel_m_reg)
        begin
            pos_reg <= AW'(mod_rem);
        end
    end

    // with p of zero the mod p result goes unused: the m pass takes the full 64 bits
    assign mod_go  = cmd.modp_go || cmd.modm_go;
    assign mod_dvd = (cmd.modm_go && prime_modulus != '0)
                   ? KEY_W'(mod_in_reg) : hval_reg;
    assign mod_dvs = cmd.modm_go ? PRIME_W'(m_eff) : prime_modulus;

    bfm_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (mod_dvd),
        .divisor   (mod_dvs),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign ram_we   = cmd.clr_step || cmd.mem_wr;
    assign ram_wd   = cmd.mem_wr;
    assign ram_addr = cmd.clr_step ? clr_reg : pos_reg;

    bfm_ram #(
        .WIDTH (1),
        .DEPTH (FILTER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wd),
        .rdata (ram_rd)
    );

    assign sts.clr_last  = (clr_reg == AW'(FILTER_DEPTH - 1));
    assign sts.hash_done = hash_done_reg;
    assign sts.mod_done  = mod_done;
    assign sts.last_hash = (HCNT_W'(hidx_reg) + HCNT_W'(1) >= r_eff);
    assign sts.is_insert = !op_reg;
    assign maybe_present = res_reg;

endmodule
`default_nettype wire

// ===== sv/bfm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_ctrl: sequencing state machine
// clearing pass, then per item: hash, mod p, mod m, bit access per hash
// ----------------------------------------------------------------------------
module bfm_ctrl
    import bfm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire bfm_sts_t sts,
    output bfm_cmd_t      cmd,
    output logic          busy,
    output logic          done
);

    bfm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_go = 1'b1;
                state_next  = ST_HASH_WAIT;
            end
            ST_HASH_WAIT:
            begin
                if (sts.hash_done)
                begin
                    state_next = ST_MODP;
                end
            end
            ST_MODP:
            begin
                cmd.modp_go = 1'b1;
                state_next  = ST_MODP_WAIT;
            end
            ST_MODP_WAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_MODM;
                end
            end
            ST_MODM:
            begin
                cmd.modm_go = 1'b1;
                state_next  = ST_MODM_WAIT;
            end
            ST_MODM_WAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                cmd.mem_rd = 1'b1;
                cmd.mem_wr = sts.is_insert;
                state_next = ST_MEM_WAIT;
            end
            ST_MEM_WAIT:
            begin
                cmd.next_hash = 1'b1;
                state_next    = sts.last_hash ? ST_DONE : ST_HASH;
            end
            ST_DONE:
            begin
                cmd.result = !sts.is_insert;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = cmd.result;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: bloom filter membership testbench
// drives insert and query items, predicts each query answer with a local bit
// store and hash arithmetic, and compares every done strobe against it
// ----------------------------------------------------------------------------
module tb_top
    import bfm_pkg::*;
;

    localparam int unsigned DEPTH  = FILTER_DEPTH_DEF;
    localparam int unsigned NHASH  = MAX_HASHES_DEF;
    localparam int unsigned CW     = COEF_WIDTH_DEF;
    localparam logic        OP_INS = 1'b0;
    localparam logic        OP_QRY = 1'b1;
    localparam int          IDLE_CYCLES = 1200;

    typedef struct {
        logic        op;
        logic [63:0] k;
    } bloom_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        opcode = 1'b0;
    logic [63:0] key = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    wire         busy;
    wire         done;
    wire         maybe_present;
    wire [63:0]  prdata;
    wire         pready;

    bloom_filter_membership u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .key(key), .done(done), .maybe_present(maybe_present),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // shadow copy of the filter and its settings
    bit          shadow_bits [DEPTH];
    logic [16:0] m_reg = 17'd65536;
    logic [2:0]  r_reg = 3'd4;
    logic [31:0] p_reg = 32'd65521;
    logic [63:0] a_reg = '0;
    logic [63:0] b_reg = '0;

    bloom_item_t pending_items [$];
    logic        expected_answers [$];
    int          mismatches = 0;
    int          wait_left = 0;
    bit          driving = 1'b0;

    // sampled busy at the last rising edge tells whether the item went in
    logic busy_at_edge = 1'b1;
    bit   cfg_active = 1'b0;

    function automatic logic [63:0] coef_of(logic [63:0] packed_v, int idx);
        if (idx * CW >= 64)
            return 64'd0;
        return (packed_v >> (idx * CW)) & ((64'd1 << CW) - 1);
    endfunction

    // apply an item to the shadow filter; returns the query answer
    function automatic logic apply_to_filter(logic op, logic [63:0] k);
        logic [63:0] m_eff;
        logic [63:0] v;
        int          r_eff;
        logic        all_set;
        m_eff = (m_reg == 0) ? 64'd1 : ((m_reg > DEPTH) ? 64'(DEPTH) : 64'(m_reg));
        r_eff = (r_reg == 0) ? 1 : ((r_reg > NHASH) ? NHASH : int'(r_reg));
        all_set = 1'b1;
        for (int i = 0; i < r_eff; i++)
        begin
            v = coef_of(a_reg, i) * k + coef_of(b_reg, i);
            if (p_reg != 0)
                v = v % 64'(p_reg);
            v = v % m_eff;
            if (op == OP_INS)
                shadow_bits[v] = 1'b1;
            else if (!shadow_bits[v])
                all_set = 1'b0;
        end
        return all_set;
    endfunction

    // driver: one item per handshake, random gap after each accept
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy_at_edge)
            begin
                start     <= 1'b0;
                wait_left <= $urandom_range(0, 13);
            end
            else if (!start && pending_items.size() > 0 && !cfg_active)
            begin
                if (wait_left > 0)
                    wait_left <= wait_left - 1;
                else
                begin
                    opcode <= pending_items[0].op;
                    key    <= pending_items[0].k;
                    start  <= 1'b1;
                end
            end
        end
    end

    // monitor: accept items and results at the rising edge
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
        begin
            bloom_item_t it;
            it = pending_items.pop_front();
            if (it.op == OP_QRY)
                expected_answers.push_back(apply_to_filter(it.op, it.k));
            else
                void'(apply_to_filter(it.op, it.k));
        end
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result maybe_present=%0b", maybe_present);
            end
            else
            begin
                logic exp_v;
                exp_v = expected_answers.pop_front();
                if (exp_v !== maybe_present)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0b got %0b", exp_v, maybe_present);
                end
            end
        end
    end

    // register write through the apb port; only called while idle
    task automatic reg_write(reg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(idx) * 6'd8; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_BIT_COUNT:  m_reg = val[16:0];
            REG_HASH_COUNT: r_reg = val[2:0];
            REG_PRIME:      p_reg = val[31:0];
            REG_MULT:       a_reg = val;
            REG_ADD:        b_reg = val;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // wait until every item is in, every answer out, and the block is quiet
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_answers.size() > 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic configure(logic [16:0] m, logic [2:0] r, logic [31:0] p,
                             logic [63:0] a, logic [63:0] b);
        cfg_active = 1'b1;
        reg_write(REG_BIT_COUNT, 64'(m));
        reg_write(REG_HASH_COUNT, 64'(r));
        reg_write(REG_PRIME, 64'(p));
        reg_write(REG_MULT, a);
        reg_write(REG_ADD, b);
        cfg_active = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push(logic op, logic [63:0] k);
        bloom_item_t it;
        it.op = op;
        it.k = k;
        pending_items.push_back(it);
    endtask

    // random phase: inserts mixed with queries of inserted keys and of fresh ones
    task automatic random_burst(int n);
        logic [63:0] seen [$];
        logic [63:0] k;
        for (int i = 0; i < n; i++)
        begin
            if (seen.size() > 0 && $urandom_range(0, 1))
                push(OP_QRY, seen[$urandom_range(0, seen.size() - 1)]);
            else if ($urandom_range(0, 3) == 0)
                push(OP_QRY, rand64());
            else
            begin
                k = ($urandom_range(0, 4) == 0) ? 64'(~$urandom_range(0, 7)) : rand64();
                seen.push_back(k);
                push(OP_INS, k);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, all coefficients zero so every key hits bit 0
        push(OP_QRY, 64'd0);
        push(OP_INS, 64'hFFFF_FFFF_FFFF_FFFF);
        push(OP_QRY, 64'd0);
        push(OP_QRY, 64'h8000_0000_0000_0001);
        drain();

        // zero bit and hash counts, zero prime, full coefficients
        configure(17'd0, 3'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push(OP_QRY, 64'd12345);
        push(OP_INS, 64'hFFFF_FFFF_FFFF_FFFF);
        push(OP_QRY, 64'd0);
        drain();

        // counts above their limits saturate, largest p value
        configure(17'h1FFFF, 3'd7, 32'hFFFF_FFFF, 64'h0001_FFFF_8000_7FFF,
                  64'hFFFF_0000_1234_0001);
        push(OP_INS, 64'd0);
        push(OP_QRY, 64'd0);
        push(OP_QRY, 64'd1);
        push(OP_INS, 64'hFFFF_FFFF_FFFF_FFFF);
        push(OP_QRY, 64'hFFFF_FFFF_FFFF_FFFF);
        push(OP_QRY, 64'hAAAA_5555_AAAA_5555);
        drain();

        // random phases, small filters make hits common
        for (int ph = 0; ph < 11; ph++)
        begin
            configure(17'($urandom_range(1, (ph % 3 == 0) ? 65536 : 300)),
                      3'($urandom_range(0, 7)),
                      (ph == 5) ? 32'd2 : $urandom(),
                      rand64(), rand64());
            random_burst(50);
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // timeout covering the clearing pass plus ~570 items and their gaps
    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/bfm_pkg.sv
sv/bfm_ram.sv
sv/bfm_mod.sv
sv/bfm_datapath.sv
sv/bfm_ctrl.sv
sv/bloom_filter_membership.sv
tb/tb_top.sv
